// ===== hw/rtl/s2a_pkg.sv =====
`timescale 1ns / 1ps
// Package for the scan code to ASCII translator with character FIFO.
// Holds the set-1 scan code constants and the unshifted and shifted key maps.
// No dependencies.

package s2a_pkg;

    // Set-1 scan codes that get special handling.
    localparam logic [7:0] ScLshift   = 8'h2A;
    localparam logic [7:0] ScRshift   = 8'h36;
    localparam logic [7:0] ScCaps     = 8'h3A;
    localparam logic [7:0] ScFkeyLo   = 8'h3B;
    localparam logic [7:0] ScFkeyHi   = 8'h44;
    localparam logic [7:0] ScBreak    = 8'h80;
    localparam logic [7:0] ScCapsBrk  = ScCaps | ScBreak;
    localparam logic [7:0] ScLshBrk   = ScLshift | ScBreak;
    localparam logic [7:0] ScRshBrk   = ScRshift | ScBreak;

    // Letter key ranges, where caps lock flips the shift sense.
    localparam logic [6:0] LetRow1Lo  = 7'h10;
    localparam logic [6:0] LetRow1Hi  = 7'h19;
    localparam logic [6:0] LetRow2Lo  = 7'h1E;
    localparam logic [6:0] LetRow2Hi  = 7'h26;
    localparam logic [6:0] LetRow3Lo  = 7'h2C;
    localparam logic [6:0] LetRow3Hi  = 7'h32;

    // Request kinds carried on the input tuser bit.
    localparam logic KindScan = 1'b0;
    localparam logic KindRead = 1'b1;

    function automatic logic is_letter(input logic [6:0] code);
        is_letter = (code >= LetRow1Lo && code <= LetRow1Hi) ||
                    (code >= LetRow2Lo && code <= LetRow2Hi) ||
                    (code >= LetRow3Lo && code <= LetRow3Hi);
    endfunction

    // Unshifted key map. Codes past the space bar map to zero.
    function automatic logic [7:0] plain_char(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'h01: ch = 8'h1B;  7'h02: ch = "1";    7'h03: ch = "2";    7'h04: ch = "3";
            7'h05: ch = "4";    7'h06: ch = "5";    7'h07: ch = "6";    7'h08: ch = "7";
            7'h09: ch = "8";    7'h0A: ch = "9";    7'h0B: ch = "0";    7'h0C: ch = "-";
            7'h0D: ch = "=";    7'h0E: ch = 8'h08;  7'h0F: ch = 8'h09;  7'h10: ch = "q";
            7'h11: ch = "w";    7'h12: ch = "e";    7'h13: ch = "r";    7'h14: ch = "t";
            7'h15: ch = "y";    7'h16: ch = "u";    7'h17: ch = "i";    7'h18: ch = "o";
            7'h19: ch = "p";    7'h1A: ch = "[";    7'h1B: ch = "]";    7'h1C: ch = 8'h0D;
            7'h1E: ch = "a";    7'h1F: ch = "s";    7'h20: ch = "d";    7'h21: ch = "f";
            7'h22: ch = "g";    7'h23: ch = "h";    7'h24: ch = "j";    7'h25: ch = "k";
            7'h26: ch = "l";    7'h27: ch = ";";    7'h2C: ch = "z";    7'h2D: ch = "x";
            7'h2E: ch = "c";    7'h2F: ch = "v";    7'h30: ch = "b";    7'h31: ch = "n";
            7'h32: ch = "m";    7'h33: ch = ",";    7'h34: ch = ".";    7'h35: ch = "/";
            7'h37: ch = "*";    7'h39: ch = " ";
            default: ch = 8'h00;
        endcase
        plain_char = ch;
    endfunction

    // Shifted key map.
    function automatic logic [7:0] upper_char(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'h01: ch = 8'h1B;  7'h02: ch = "!";    7'h03: ch = "@";    7'h04: ch = "#";
            7'h05: ch = "$";    7'h06: ch = "%";    7'h07: ch = "^";    7'h08: ch = "&";
            7'h09: ch = "*";    7'h0A: ch = "(";    7'h0B: ch = ")";    7'h0C: ch = "_";
            7'h0D: ch = "+";    7'h0E: ch = 8'h08;  7'h0F: ch = 8'h09;  7'h10: ch = "Q";
            7'h11: ch = "W";    7'h12: ch = "E";    7'h13: ch = "R";    7'h14: ch = "T";
            7'h15: ch = "Y";    7'h16: ch = "U";    7'h17: ch = "I";    7'h18: ch = "O";
            7'h19: ch = "P";    7'h1A: ch = "{";    7'h1B: ch = "}";    7'h1C: ch = 8'h0D;
            7'h1E: ch = "A";    7'h1F: ch = "S";    7'h20: ch = "D";    7'h21: ch = "F";
            7'h22: ch = "G";    7'h23: ch = "H";    7'h24: ch = "J";    7'h25: ch = "K";
            7'h26: ch = "L";    7'h27: ch = ":";    7'h29: ch = "~";    7'h2B: ch = "|";
            7'h2C: ch = "Z";    7'h2D: ch = "X";    7'h2E: ch = "C";    7'h2F: ch = "V";
            7'h30: ch = "B";    7'h31: ch = "N";    7'h32: ch = "M";    7'h33: ch = "<";
            7'h34: ch = ">";    7'h35: ch = "?";    7'h37: ch = "*";    7'h39: ch = " ";
            default: ch = 8'h00;
        endcase
        upper_char = ch;
    endfunction

endpackage

// ===== hw/rtl/scancode_to_ascii_fifo_core.sv =====
`timescale 1ns / 1ps
// A request passes two register stages (input register, result register) on its way to
// the output port.
// Throughput: one request per cycle while results are taken; the FIFO update and key map
// lookup fit between the two registers, and the FIFO memory has one port of each kind.
// Reset (synchronous, active low) empties the FIFO, clears shift and caps lock state and
// drops any request in flight. The character memory itself is not cleared.
//
// File contents: top level of the scan code to ASCII translator. Depends on s2a_pkg.

module scancode_to_ascii_fifo_core
    import s2a_pkg::*;
#(
    parameter int FIFO_DEPTH    = 64,
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input stream. One request per transfer.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] scan_byte
    input  logic        i_s_axis_tuser,   // [0] kind: 0 scan byte, 1 read one character

    // Result stream. One result per request.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [6:0] char_out, [7] char_valid, [8] read_empty,
                                          // [9] enqueued, [10] dropped_full,
                                          // [11] shift_active, [12] caps_active, [15:13] zero
);

    // Pointer and fill count widths follow the FIFO depth; a depth that is not a
    // power of two wraps the pointers by compare.
    localparam int         PtrW     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int         CntW     = $clog2(FIFO_DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast  = PtrW'(FIFO_DEPTH - 1);
    localparam logic [CntW-1:0] CntFull  = CntW'(FIFO_DEPTH);
    localparam logic [7:0] TblLimit = 8'(TABLE_ENTRIES);

    // ------------------------------------------------------------------
    // Input register. The stage moves forward whenever the result register
    // is empty or its contents are being taken this cycle, so a new request
    // is accepted every cycle while the downstream side keeps up.
    // ------------------------------------------------------------------
    logic        r_in_valid;
    logic        r_kind;
    logic [7:0]  r_scan;
    logic        advance;
    logic        in_fire;

    logic        r_out_valid;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind <= i_s_axis_tuser;
            r_scan <= i_s_axis_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Keyboard and FIFO state.
    // ------------------------------------------------------------------
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [CntW-1:0] r_fill,   n_fill;
    logic [1:0]      r_shift_cnt, n_shift_cnt;
    logic            r_shift_flag, n_shift_flag;
    logic            r_caps_flag,  n_caps_flag;

    logic            push;       // store a translated character
    logic            pop;        // read the oldest character
    logic            read_empty;
    logic            dropped;
    logic            use_upper;
    logic [6:0]      ch_new;
    logic            fifo_full;
    logic            fifo_empty;

    assign fifo_full  = (r_fill == CntFull);
    assign fifo_empty = (r_fill == '0);

    // Translation of a make code. Letters use shift XOR caps; everything else
    // uses shift alone. Codes at or beyond the table length give zero.
    always_comb begin
        logic [7:0] ch_plain;
        logic [7:0] ch_upper;
        ch_plain  = plain_char(r_scan[6:0]);
        ch_upper  = upper_char(r_scan[6:0]);
        use_upper = is_letter(r_scan[6:0]) ? (r_shift_flag ^ r_caps_flag) : r_shift_flag;
        if (r_scan >= TblLimit) begin
            ch_new = '0;
        end else if (use_upper) begin
            ch_new = ch_upper[6:0];
        end else begin
            ch_new = ch_plain[6:0];
        end
    end

    // Request decode and next state.
    always_comb begin
        logic want_push;
        want_push    = 1'b0;
        pop          = 1'b0;
        read_empty   = 1'b0;
        n_shift_cnt  = r_shift_cnt;
        n_shift_flag = r_shift_flag;
        n_caps_flag  = r_caps_flag;

        if (r_kind == KindRead) begin
            pop        = !fifo_empty;
            read_empty = fifo_empty;
        end else begin
            unique case (r_scan) inside
                [ScFkeyLo:ScFkeyHi]: begin
                    // Function key makes produce nothing.
                end
                ScCaps: begin
                    n_caps_flag = !r_caps_flag;
                end
                ScCapsBrk: begin
                end
                ScLshift, ScRshift: begin
                    if (r_shift_cnt != 2'd3) begin
                        n_shift_cnt = r_shift_cnt + 2'd1;
                    end
                    n_shift_flag = 1'b1;
                end
                ScLshBrk, ScRshBrk: begin
                    if (r_shift_cnt != 2'd0) begin
                        n_shift_cnt = r_shift_cnt - 2'd1;
                    end
                    n_shift_flag = (n_shift_cnt != 2'd0);
                end
                default: begin
                    // Remaining break codes are ignored; make codes translate.
                    want_push = ((r_scan & ScBreak) == 8'h00);
                end
            endcase
        end

        push    = want_push && !fifo_full;
        dropped = want_push && fifo_full;

        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_fill   = r_fill;
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
            n_fill   = r_fill - 1'b1;
        end
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
            n_fill   = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr     <= '0;
            r_wr_ptr     <= '0;
            r_fill       <= '0;
            r_shift_cnt  <= '0;
            r_shift_flag <= 1'b0;
            r_caps_flag  <= 1'b0;
        end else if (advance) begin
            r_rd_ptr     <= n_rd_ptr;
            r_wr_ptr     <= n_wr_ptr;
            r_fill       <= n_fill;
            r_shift_cnt  <= n_shift_cnt;
            r_shift_flag <= n_shift_flag;
            r_caps_flag  <= n_caps_flag;
        end
    end

    // ------------------------------------------------------------------
    // Character memory. One write port, one registered read port. The read
    // data register doubles as the char_out field of the result register and
    // holds zero for every result that is not a successful read.
    // ------------------------------------------------------------------
    logic [6:0] mem_chars [FIFO_DEPTH];
    logic [6:0] r_rd_q;

    always_ff @(posedge i_clk) begin
        if (advance && push) begin
            mem_chars[r_wr_ptr] <= ch_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (pop) begin
                r_rd_q <= mem_chars[r_rd_ptr];
            end else begin
                r_rd_q <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic r_char_valid;
    logic r_read_empty;
    logic r_enqueued;
    logic r_dropped;
    logic r_shift_act;
    logic r_caps_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_char_valid <= pop;
            r_read_empty <= read_empty;
            r_enqueued   <= push;
            r_dropped    <= dropped;
            r_shift_act  <= n_shift_flag;
            r_caps_act   <= n_caps_flag;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_caps_act, r_shift_act, r_dropped, r_enqueued,
                              r_read_empty, r_char_valid, r_rd_q};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CntFull)
        else $error("FIFO fill count exceeds depth");

    a_shift_flag_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shift_flag == (r_shift_cnt != 2'd0))
        else $error("shift flag disagrees with shift count");

    a_push_grows_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && push |=> r_fill == $past(r_fill) + 1'b1)
        else $error("stored character did not raise the fill count");

    a_pop_shrinks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && pop |=> r_fill == $past(r_fill) - 1'b1)
        else $error("read character did not lower the fill count");

    a_result_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $countones({r_char_valid, r_read_empty, r_enqueued, r_dropped}) <= 1)
        else $error("result carries more than one outcome flag");

    a_empty_read_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_char_valid |-> r_rd_q == '0)
        else $error("character present on a result that is not a successful read");

endmodule
